FILE: hdl/open_addressing_hash_table_unit_macros.svh
// Assertion macros for the open addressing hash table unit.
// Used by open_addressing_hash_table_unit.sv; relies on clk_i and rst_ni in scope.
`ifndef OPEN_ADDRESSING_HASH_TABLE_UNIT_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define OAHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OAHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/oaht_pkg.sv
// Package for the open addressing hash table unit: payload structs, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps

package oaht_pkg;

  localparam int TABLE_DEPTH_DEF   = 64;
  localparam int KEY_BYTES_MAX_DEF = 8;
  localparam int HASH_MULT         = 13;
  localparam int CFG_W             = 7;
  localparam int KEY_FIELD_W       = 64;
  localparam int LEN_W             = 4;
  localparam int VALUE_W           = 32;
  localparam int SLOT_OUT_W        = 6;
  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd50;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;

  typedef enum logic [2:0] {
    StDone    = 3'd0,
    StFull    = 3'd1,
    StExists  = 3'd2,
    StMissing = 3'd3,
    StEmpty   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MarkEmpty = 2'd0,
    MarkUsed  = 2'd1,
    MarkGone  = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    SIdle,
    SHash,
    SDecide,
    SFindRd,
    SFindCmp,
    SIns
  } state_e;

  typedef struct packed {
    logic [1:0]               operation;
    logic [KEY_FIELD_W-1:0]   key_bytes;
    logic [LEN_W-1:0]         key_length;
    logic signed [VALUE_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    status_e                   status;
    logic signed [VALUE_W-1:0] found_value;
    logic [SLOT_OUT_W-1:0]     slot_index;
  } res_t;

endpackage

FILE: hdl/open_addressing_hash_table_unit.sv
// Top level of the open addressing hash table unit (linear probing).
// Depends on oaht_pkg and open_addressing_hash_table_unit_macros.svh.
`timescale 1ns / 1ps

// One request at a time: start is taken while busy is low, and exactly one
// result follows on res_o with done_o high for one cycle; the receiver cannot
// stall. XW is the hash remainder width (11 bits at a depth of 64): one
// shared compare-subtract unit reduces (13*h + byte) modulo the table size
// one shifted divisor per cycle. Each search probe reads the registered slot
// memory and then compares, and a successful insert ends with a slot write.
// An insert takes the first removed or empty slot seen on the search path.
// Slot marks sit in memory qualified by per-slot flags cleared by reset, so
// no clearing pass is needed.
module open_addressing_hash_table_unit #(
  parameter int TABLE_DEPTH   = oaht_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BYTES_MAX = oaht_pkg::KEY_BYTES_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  oaht_pkg::req_t              req_i,
  output logic                        done_o,
  output oaht_pkg::res_t              res_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [oaht_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int SZ_W   = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W  = 8 * KEY_BYTES_MAX;
  localparam int XW     = $clog2(oaht_pkg::HASH_MULT * (TABLE_DEPTH - 1) + 256);
  localparam int KW     = $clog2(XW);
  localparam int DW     = XW + SZ_W;
  localparam logic [KW-1:0] KTOP = KW'(XW - 1);

  oaht_pkg::state_e state_q, state_d;
  oaht_pkg::mark_e  mark_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]           seen_q;

  logic [oaht_pkg::CFG_W-1:0]       cfg_q;
  logic [SZ_W-1:0]                  cnt_q, cnt_d;
  logic [1:0]                       op_q, op_d;
  logic [oaht_pkg::KEY_FIELD_W-1:0] key_q, key_d;
  logic [oaht_pkg::LEN_W-1:0]       len_q, len_d;
  logic signed [oaht_pkg::VALUE_W-1:0] val_q, val_d;
  logic [XW-1:0]                    r_q, r_d;
  logic [KW-1:0]                    k_q, k_d;
  logic [oaht_pkg::LEN_W-1:0]       bidx_q, bidx_d;
  logic [IDX_W-1:0]                 pos_q, pos_d, free_q, free_d, pos_nxt;
  logic                             free_ok_q, free_ok_d;
  logic [SZ_W-1:0]                  n_q, n_d;
  logic                             done_q, done_d;
  oaht_pkg::res_t                   res_q, res_d;

  logic [KEY_W-1:0]                 key_mem [TABLE_DEPTH];
  logic [oaht_pkg::LEN_W-1:0]       len_mem [TABLE_DEPTH];
  logic [oaht_pkg::VALUE_W-1:0]     val_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]                 rd_key_q;
  logic [oaht_pkg::LEN_W-1:0]       rd_len_q;
  logic [oaht_pkg::VALUE_W-1:0]     rd_val_q;
  oaht_pkg::mark_e                  rd_mark_q;

  logic                             mem_we, mark_set, mark_clr;
  logic [31:0]                      size32, slot32;
  logic [SZ_W-1:0]                  size;
  logic [DW-1:0]                    sub;
  logic [XW-1:0]                    rem;
  logic [2:0]                       nb;
  logic [oaht_pkg::LEN_W-1:0]       len_cl;
  logic                             hit, last_probe;
  oaht_pkg::mark_e                  mark_cur;

  always_comb begin
    if (cfg_q == '0) begin
      size32 = 32'd1;
    end else if (32'(cfg_q) > TABLE_DEPTH) begin
      size32 = 32'(TABLE_DEPTH);
    end else begin
      size32 = 32'(cfg_q);
    end
  end
  assign size = size32[SZ_W-1:0];

  // shared compare-subtract unit
  assign sub = DW'(size) << k_q;
  assign rem = ({{SZ_W{1'b0}}, r_q} >= sub) ? (r_q - sub[XW-1:0]) : r_q;
  assign nb  = bidx_q[2:0] + 3'd1;

  assign len_cl = (32'(req_i.key_length) > KEY_BYTES_MAX) ? oaht_pkg::LEN_W'(KEY_BYTES_MAX)
                                                           : req_i.key_length;

  assign mark_cur   = rd_mark_q;
  assign pos_nxt    = (32'(pos_q) + 32'd1 == 32'(size)) ? '0 : pos_q + IDX_W'(1);
  assign last_probe = (n_q + SZ_W'(1) == size);
  assign hit        = (mark_cur == oaht_pkg::MarkUsed) && (rd_len_q == len_q) &&
                      (rd_key_q == key_q[KEY_W-1:0]);
  assign slot32     = 32'(pos_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    op_d      = op_q;
    key_d     = key_q;
    len_d     = len_q;
    val_d     = val_q;
    r_d       = r_q;
    k_d       = k_q;
    bidx_d    = bidx_q;
    pos_d     = pos_q;
    free_d    = free_q;
    free_ok_d = free_ok_q;
    n_d       = n_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mark_set  = 1'b0;
    mark_clr  = 1'b0;
    unique case (state_q)
      oaht_pkg::SIdle: begin
        if (start) begin
          op_d  = req_i.operation;
          len_d = len_cl;
          val_d = req_i.entry_value;
          for (int j = 0; j < 8; j++) begin
            key_d[8*j +: 8] = (j < 32'(len_cl)) ? req_i.key_bytes[8*j +: 8] : 8'd0;
          end
          r_d    = XW'(req_i.key_bytes[7:0]);
          k_d    = KTOP;
          bidx_d = '0;
          if (len_cl == '0) begin
            r_d     = '0;
            state_d = oaht_pkg::SDecide;
          end else begin
            state_d = oaht_pkg::SHash;
          end
        end
      end
      oaht_pkg::SHash: begin
        r_d = rem;
        k_d = k_q - KW'(1);
        if (k_q == '0) begin
          if (bidx_q + oaht_pkg::LEN_W'(1) == len_q) begin
            state_d = oaht_pkg::SDecide;
          end else begin
            bidx_d = bidx_q + oaht_pkg::LEN_W'(1);
            r_d    = XW'(rem * oaht_pkg::HASH_MULT) + XW'(key_q[{nb, 3'b000} +: 8]);
            k_d    = KTOP;
          end
        end
      end
      oaht_pkg::SDecide: begin
        pos_d     = r_q[IDX_W-1:0];
        free_ok_d = 1'b0;
        n_d       = '0;
        res_d     = '{status: oaht_pkg::StDone, found_value: '0, slot_index: '0};
        if (op_q == oaht_pkg::OP_INSERT && cnt_q >= size) begin
          res_d.status = oaht_pkg::StFull;
          done_d       = 1'b1;
          state_d      = oaht_pkg::SIdle;
        end else if (op_q == oaht_pkg::OP_REMOVE && cnt_q == '0) begin
          res_d.status = oaht_pkg::StEmpty;
          done_d       = 1'b1;
          state_d      = oaht_pkg::SIdle;
        end else begin
          state_d = oaht_pkg::SFindRd;
        end
      end
      oaht_pkg::SFindRd: begin
        state_d = oaht_pkg::SFindCmp;
      end
      oaht_pkg::SFindCmp: begin
        if (mark_cur != oaht_pkg::MarkEmpty && hit) begin
          done_d  = 1'b1;
          state_d = oaht_pkg::SIdle;
          if (op_q == oaht_pkg::OP_INSERT) begin
            res_d.status = oaht_pkg::StExists;
          end else if (op_q == oaht_pkg::OP_REMOVE) begin
            mark_clr         = 1'b1;
            cnt_d            = cnt_q - SZ_W'(1);
            res_d.slot_index = slot32[oaht_pkg::SLOT_OUT_W-1:0];
          end else begin
            res_d.found_value = rd_val_q;
            res_d.slot_index  = slot32[oaht_pkg::SLOT_OUT_W-1:0];
          end
        end else if (mark_cur == oaht_pkg::MarkEmpty || last_probe) begin
          if (op_q == oaht_pkg::OP_INSERT) begin
            if (free_ok_q || mark_cur != oaht_pkg::MarkUsed) begin
              pos_d   = free_ok_q ? free_q : pos_q;
              state_d = oaht_pkg::SIns;
            end else begin
              res_d.status = oaht_pkg::StFull;
              done_d       = 1'b1;
              state_d      = oaht_pkg::SIdle;
            end
          end else begin
            res_d.status = oaht_pkg::StMissing;
            done_d       = 1'b1;
            state_d      = oaht_pkg::SIdle;
          end
        end else begin
          // first removed slot on the path is the insert target
          if (!free_ok_q && mark_cur != oaht_pkg::MarkUsed) begin
            free_d    = pos_q;
            free_ok_d = 1'b1;
          end
          pos_d   = pos_nxt;
          n_d     = n_q + SZ_W'(1);
          state_d = oaht_pkg::SFindRd;
        end
      end
      oaht_pkg::SIns: begin
        mem_we           = 1'b1;
        mark_set         = 1'b1;
        cnt_d            = cnt_q + SZ_W'(1);
        res_d.slot_index = slot32[oaht_pkg::SLOT_OUT_W-1:0];
        done_d           = 1'b1;
        state_d          = oaht_pkg::SIdle;
      end
      default: begin
        state_d = oaht_pkg::SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oaht_pkg::SIdle;
      cfg_q   <= oaht_pkg::SIZE_RESET;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      seen_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      if (mark_set) begin
        seen_q[pos_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    len_q     <= len_d;
    val_q     <= val_d;
    r_q       <= r_d;
    k_q       <= k_d;
    bidx_q    <= bidx_d;
    pos_q     <= pos_d;
    free_q    <= free_d;
    free_ok_q <= free_ok_d;
    n_q       <= n_d;
    res_q     <= res_d;
  end

  // slot payload and mark memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[pos_q] <= key_q[KEY_W-1:0];
      len_mem[pos_q] <= len_q;
      val_mem[pos_q] <= val_q;
    end
    if (mark_set) begin
      mark_mem[pos_q] <= oaht_pkg::MarkUsed;
    end else if (mark_clr) begin
      mark_mem[pos_q] <= oaht_pkg::MarkGone;
    end
    if (state_q == oaht_pkg::SFindRd) begin
      rd_key_q <= key_mem[pos_q];
      rd_len_q <= len_mem[pos_q];
      rd_val_q <= val_mem[pos_q];
      if (seen_q[pos_q]) begin
        rd_mark_q <= mark_mem[pos_q];
      end else begin
        rd_mark_q <= oaht_pkg::MarkEmpty;
      end
    end
  end

  assign busy        = (state_q != oaht_pkg::SIdle);
  assign cfg_ready_o = (state_q == oaht_pkg::SIdle);
  assign done_o      = done_q;
  assign res_o       = res_q;

`include "open_addressing_hash_table_unit_macros.svh"

  `OAHT_ASSERT_NXT(a_done_single, done_o, !done_o, "result strobe held past one beat")
  `OAHT_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")
  `OAHT_ASSERT_IMP(a_cnt_range, 1'b1, 32'(cnt_q) <= TABLE_DEPTH, "entry count over depth")
  `OAHT_ASSERT_IMP(a_fail_zero, done_o && res_o.status != oaht_pkg::StDone,
    res_o.slot_index == '0 && res_o.found_value == '0, "failed beat carries payload")

endmodule
